[rtl/cvet_pkg.sv]
package cvet_pkg;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_UPPER_LIMIT = 1'b0,
		REG_LOWER_LIMIT = 1'b1
	} cfg_reg_t;

	localparam int unsigned VOLT_W  = 16;
	localparam int unsigned INDEX_W = 8;

	localparam logic [VOLT_W-1:0] UPPER_LIMIT_RESET = 16'd50000;
	localparam logic [VOLT_W-1:0] LOWER_LIMIT_RESET = 16'd20000;
	localparam logic [VOLT_W-1:0] MIN_SEED          = 16'd32767;

	// floor(v / 1000) == (v * 67109) >> 26 for every 16-bit v
	localparam int unsigned       RECIP_W     = 17;
	localparam logic [RECIP_W-1:0] VOLT_RECIP = 17'd67109;
	localparam int unsigned       RECIP_SHIFT = 26;
	localparam int unsigned       PROD_W      = VOLT_W + RECIP_W;
	localparam int unsigned       QUOT_W      = 7;

endpackage

[rtl/cell_voltage_extrema_tracker_core.sv]
// Channel   Signals                                     Direction  Moves
// config    cfg_wr_en, cfg_index, cfg_data              in         limit register write
// input     in_valid/in_ready, cell_voltage, last_cell  in         one cell reading
// output    out_valid/out_ready, max_*, min_*,          out        one scan summary
//           pack_total, invalid_seen, invalid_index
//
// Throughput is one reading per cycle unless input stalls; a reading passes an input
// register and its compare, select and divide-by-1000 logic then updates the scan state.
// A summary is registered in the output register as the last_cell request leaves the input register.
// Reset loads the limits 50000/20000 and clears the scan state (minimum seed 32767).
// Only a last-cell request waiting on a full, unread output register stalls input.
module cell_voltage_extrema_tracker_core #(
	parameter int MAX_CELLS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [0:0]                  cfg_index,
	input  logic [cvet_pkg::VOLT_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cvet_pkg::VOLT_W-1:0] cell_voltage,
	input  logic                        last_cell,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cvet_pkg::VOLT_W-1:0]  max_voltage,
	output logic [cvet_pkg::INDEX_W-1:0] max_index,
	output logic [cvet_pkg::VOLT_W-1:0]  min_voltage,
	output logic [cvet_pkg::INDEX_W-1:0] min_index,
	output logic [cvet_pkg::VOLT_W-1:0]  pack_total,
	output logic                         invalid_seen,
	output logic [cvet_pkg::INDEX_W-1:0] invalid_index
);

	import cvet_pkg::*;

	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(MAX_CELLS - 1);

	logic [VOLT_W-1:0]  upper_q;
	logic [VOLT_W-1:0]  lower_q;

	logic               valid_s1;
	logic [VOLT_W-1:0]  volt_s1;
	logic               last_s1;
	logic               adv_s1;

	logic [VOLT_W-1:0]  max_q;
	logic [INDEX_W-1:0] max_idx_q;
	logic [VOLT_W-1:0]  min_q;
	logic [INDEX_W-1:0] min_idx_q;
	logic [VOLT_W-1:0]  sum_q;
	logic               bad_q;
	logic [INDEX_W-1:0] bad_idx_q;
	logic [INDEX_W-1:0] cnt_q;

	logic [VOLT_W-1:0]  max_nxt;
	logic [INDEX_W-1:0] max_idx_nxt;
	logic [VOLT_W-1:0]  min_nxt;
	logic [INDEX_W-1:0] min_idx_nxt;
	logic [VOLT_W-1:0]  sum_nxt;
	logic               bad_nxt;
	logic [INDEX_W-1:0] bad_idx_nxt;
	logic [PROD_W-1:0]  prod;
	logic [QUOT_W-1:0]  quot;
	logic               over_upper;
	logic               under_lower;

	logic               out_valid_q;
	logic [VOLT_W-1:0]  out_max_q;
	logic [INDEX_W-1:0] out_max_idx_q;
	logic [VOLT_W-1:0]  out_min_q;
	logic [INDEX_W-1:0] out_min_idx_q;
	logic [VOLT_W-1:0]  out_sum_q;
	logic               out_bad_q;
	logic [INDEX_W-1:0] out_bad_idx_q;

	// Write limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UPPER_LIMIT_RESET;
			lower_q <= LOWER_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_UPPER_LIMIT: upper_q <= cfg_data;
				REG_LOWER_LIMIT: lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance unless a finished scan must wait for the output register
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			volt_s1 <= cell_voltage;
			last_s1 <= last_cell;
		end
	end

	// Divide by 1000 through a reciprocal multiply
	assign prod = PROD_W'(volt_s1) * PROD_W'(VOLT_RECIP);
	assign quot = prod[RECIP_SHIFT +: QUOT_W];

	assign over_upper  = volt_s1 >= upper_q;
	assign under_lower = volt_s1 <= lower_q;

	// Fold the reading into the scan state
	always_comb begin
		sum_nxt     = sum_q + VOLT_W'(quot);
		max_nxt     = max_q;
		max_idx_nxt = max_idx_q;
		min_nxt     = min_q;
		min_idx_nxt = min_idx_q;
		bad_nxt     = bad_q;
		bad_idx_nxt = bad_idx_q;
		if (volt_s1 > max_q && !over_upper) begin
			max_nxt     = volt_s1;
			max_idx_nxt = cnt_q;
		end
		if ((volt_s1 < min_q || min_q == '0) && !under_lower) begin
			min_nxt     = volt_s1;
			min_idx_nxt = cnt_q;
		end
		if (over_upper || under_lower) begin
			bad_nxt     = 1'b1;
			bad_idx_nxt = cnt_q;
		end
	end

	// Update the scan state, clear it after the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q     <= '0;
			max_idx_q <= '0;
			min_q     <= MIN_SEED;
			min_idx_q <= '0;
			sum_q     <= '0;
			bad_q     <= 1'b0;
			bad_idx_q <= '0;
			cnt_q     <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				max_q     <= '0;
				max_idx_q <= '0;
				min_q     <= MIN_SEED;
				min_idx_q <= '0;
				sum_q     <= '0;
				bad_q     <= 1'b0;
				bad_idx_q <= '0;
				cnt_q     <= '0;
			end else begin
				max_q     <= max_nxt;
				max_idx_q <= max_idx_nxt;
				min_q     <= min_nxt;
				min_idx_q <= min_idx_nxt;
				sum_q     <= sum_nxt;
				bad_q     <= bad_nxt;
				bad_idx_q <= bad_idx_nxt;
				cnt_q     <= (cnt_q == LAST_INDEX) ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// Hold the summary until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_max_q     <= max_nxt;
			out_max_idx_q <= max_idx_nxt;
			out_min_q     <= min_nxt;
			out_min_idx_q <= min_idx_nxt;
			out_sum_q     <= sum_nxt;
			out_bad_q     <= bad_nxt;
			out_bad_idx_q <= bad_idx_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign max_voltage   = out_max_q;
	assign max_index     = out_max_idx_q;
	assign min_voltage   = out_min_q;
	assign min_index     = out_min_idx_q;
	assign pack_total    = out_sum_q;
	assign invalid_seen  = out_bad_q;
	assign invalid_index = out_bad_idx_q;

`ifndef ASSERT_OFF
	// A summary only follows a last-cell request
	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && last_s1))
		else $error("summary without last cell");

	// A new scan starts numbering at cell zero
	a_cnt_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (cnt_q == '0 && sum_q == '0 && !bad_q))
		else $error("scan state not cleared");

	// Input stalls only behind a blocked summary
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && last_s1 && out_valid_q && !out_ready))
		else $error("unexpected input stall");

	// The running minimum never holds zero
	a_min_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		min_q != '0)
		else $error("running minimum is zero");
`endif

endmodule
